FILE: hw/rtl/ppe_pkg.sv
// Shared types, constants and helpers for the particle pool engine.
// No dependencies; imported by ppe_mul, ppe_div and the top level.
package ppe_pkg;

  localparam int POOL_SIZE_DEF = 1024;

  localparam int MUL_AW = 34;
  localparam int MUL_BW = 18;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic [31:0] TWO_PI_Q   = 32'd411775;
  localparam logic [9:0]  ROT_RATE_Q = 10'd655;
  localparam logic [16:0] T_ONE      = 17'd65536;

  localparam logic [1:0] REQ_EMIT   = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_RENDER = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [3:0] REG_COLOR_BEGIN  = 4'd0;
  localparam logic [3:0] REG_COLOR_END    = 4'd1;
  localparam logic [3:0] REG_VEL_SPREAD_X = 4'd2;
  localparam logic [3:0] REG_VEL_SPREAD_Y = 4'd3;
  localparam logic [3:0] REG_SIZE_BEGIN   = 4'd4;
  localparam logic [3:0] REG_SIZE_SPREAD  = 4'd5;
  localparam logic [3:0] REG_SIZE_END     = 4'd6;
  localparam logic [3:0] REG_LIFETIME     = 4'd7;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] spawn_x;
    logic signed [31:0] spawn_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [15:0]        rand_vx;
    logic [15:0]        rand_vy;
    logic [15:0]        rand_rot;
    logic [15:0]        rand_size;
    logic [15:0]        dt;
    logic [9:0]         index;
  } req_t;

  typedef struct packed {
    logic               shown;
    logic signed [31:0] quad_x;
    logic signed [31:0] quad_y;
    logic signed [31:0] quad_size;
    logic signed [31:0] quad_angle;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } rsp_t;

  typedef struct packed {
    logic               active;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [31:0]        angle;
    logic [31:0]        life_left;
    logic [31:0]        life_total;
    logic [31:0]        color_start;
    logic [31:0]        color_stop;
    logic signed [31:0] size_start;
    logic signed [31:0] size_stop;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  function automatic logic signed [31:0] sat32(input logic signed [36:0] x);
    logic signed [36:0] hi;
    logic signed [36:0] lo;
    hi = 37'sh007FFFFFFF;
    lo = -37'sh0080000000;
    if (x > hi) begin
      return 32'sh7FFFFFFF;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

FILE: hw/rtl/ppe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ppe_mul.sv
// Shared signed multiplier with registered product, used by the emit, tick and render sequences.
// Depends on ppe_pkg for operand widths.
module ppe_mul import ppe_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  output logic signed [MUL_PW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: hw/rtl/ppe_div.sv
// Restoring divider for the life ratio: floor(65536 * num / den), clamped to 65536.
// One quotient bit per cycle; depends on ppe_pkg.
module ppe_div import ppe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [16:0] quot
);

  logic        running;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [32:0] shifted;

  assign shifted = {rem, 1'b0};
  assign done = running && (cnt == 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= 5'd0;
    end else if (start) begin
      running <= 1'b1;
      dsr     <= den;
      if (num >= den) begin
        quot <= T_ONE;
        cnt  <= 5'd0;
      end else begin
        rem  <= num;
        quot <= 17'd0;
        cnt  <= 5'd16;
      end
    end else if (running) begin
      if (cnt == 5'd0) begin
        running <= 1'b0;
      end else begin
        cnt <= cnt - 5'd1;
        if (shifted >= {1'b0, dsr}) begin
          rem  <= 32'(shifted - {1'b0, dsr});
          quot <= {quot[15:0], 1'b1};
        end else begin
          rem  <= shifted[31:0];
          quot <= {quot[15:0], 1'b0};
        end
      end
    end
  end

endmodule

FILE: hw/rtl/particle_pool_engine.sv
// Particle pool engine top level: request sequencer, config registers, slot RAM.
// Depends on ppe_pkg, ppe_ram, ppe_mul and ppe_div.
//
// Usage: drive req and pulse start while busy is low; the transaction is taken
// at that edge and busy rises until the request is done. Emit passes S_E_VX,
// S_E_VY, S_E_SZ, S_E_ANG and writes the slot at the descending ring pointer in
// S_E_WR. Tick walks all POOL_SIZE slots through the slot RAM in turn: S_T_RD,
// S_T_CHK for an idle slot, plus S_T_MX, S_T_MY for an active one, as the single
// RAM read port and the shared multiplier demand. A render query gives rsp_valid
// high for exactly one cycle with rsp after S_R_RD, S_R_CHK, S_R_DIV (bit-serial
// divider, short when the life ratio clamps), S_R_M0 to S_R_M4 and S_R_OUT; a
// zero life total skips S_R_DIV, an inactive slot or out-of-range index gets a
// cleared rsp early. The receiver cannot stall and must take the result then.
// Busy drops as the state reaches S_IDLE, where start is sampled. Emit and tick
// give no result; request type 3 is dropped at once. Config: cfg_ready is always
// high; write only while busy is low. Reset (rst, synchronous) restores config
// defaults, then a clearing pass zeroes all POOL_SIZE slots with busy held high.
module particle_pool_engine import ppe_pkg::*; #(
  parameter int POOL_SIZE = POOL_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        rsp_valid,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SW = $clog2(POOL_SIZE);
  localparam logic [SW-1:0] LAST = SW'(POOL_SIZE - 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_E_VX, S_E_VY, S_E_SZ, S_E_ANG, S_E_WR,
    S_T_RD, S_T_CHK, S_T_MX, S_T_MY,
    S_R_RD, S_R_CHK, S_R_DIV, S_R_M0, S_R_M1, S_R_M2, S_R_M3, S_R_M4, S_R_OUT
  } state_t;

  state_t state;

  logic [31:0]        color_begin, color_end, lifetime;
  logic [30:0]        vel_spread_x, vel_spread_y, size_spread;
  logic signed [31:0] size_begin, size_end;

  req_t       rq;
  slot_rec_t  rec;
  logic [SW-1:0] ptr;
  logic [SW-1:0] emit_slot;
  logic [16:0]   t;

  logic            ram_we;
  logic [SW-1:0]   ram_waddr, ram_raddr;
  slot_rec_t       ram_wdata, ram_rdata;

  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] prod;
  logic signed [35:0]       ps;

  logic        div_start, div_done;
  logic [16:0] div_q;

  logic [SW+9:0]      idx_ext;
  logic               idx_ok;
  logic [25:0]        rot_full;
  logic signed [31:0] jit;
  logic signed [31:0] pos_y_new;
  logic [31:0]        life_new;

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);
  assign ps = prod[51:16];

  assign idx_ext = {{SW{1'b0}}, rq.index};
  assign idx_ok  = ({22'd0, rq.index} < 32'(POOL_SIZE));
  assign rot_full = {16'd0, ROT_RATE_Q} * {10'd0, rq.dt};
  assign pos_y_new = sat32(37'(rec.pos_y) + 37'(ps));
  assign life_new = (rec.life_left > {16'd0, rq.dt}) ? rec.life_left - {16'd0, rq.dt}
                                                      : 32'd0;

  always_comb begin
    jit = 32'sd0;
    unique case (state)
      S_E_VY:  jit = sat32(37'(rq.vel_x) + 37'(ps));
      S_E_SZ:  jit = sat32(37'(rq.vel_y) + 37'(ps));
      S_E_ANG: jit = sat32(37'(size_begin) + 37'(ps));
      default: jit = 32'sd0;
    endcase
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_E_VX: begin
        mul_a = $signed({3'b0, vel_spread_x});
        mul_b = $signed({2'b0, rq.rand_vx}) - 18'sd32768;
      end
      S_E_VY: begin
        mul_a = $signed({3'b0, vel_spread_y});
        mul_b = $signed({2'b0, rq.rand_vy}) - 18'sd32768;
      end
      S_E_SZ: begin
        mul_a = $signed({3'b0, size_spread});
        mul_b = $signed({2'b0, rq.rand_size}) - 18'sd32768;
      end
      S_E_ANG: begin
        mul_a = $signed({2'b0, TWO_PI_Q});
        mul_b = $signed({2'b0, rq.rand_rot});
      end
      S_T_CHK: begin
        mul_a = 34'(ram_rdata.vel_x);
        mul_b = $signed({2'b0, rq.dt});
      end
      S_T_MX: begin
        mul_a = 34'(rec.vel_y);
        mul_b = $signed({2'b0, rq.dt});
      end
      S_R_M0: begin
        mul_a = 34'(rec.size_start) - 34'(rec.size_stop);
        mul_b = $signed({1'b0, t});
      end
      S_R_M1: begin
        mul_a = $signed({26'd0, rec.color_start[31:24]}) -
                $signed({26'd0, rec.color_stop[31:24]});
        mul_b = $signed({1'b0, t});
      end
      S_R_M2: begin
        mul_a = $signed({26'd0, rec.color_start[23:16]}) -
                $signed({26'd0, rec.color_stop[23:16]});
        mul_b = $signed({1'b0, t});
      end
      S_R_M3: begin
        mul_a = $signed({26'd0, rec.color_start[15:8]}) -
                $signed({26'd0, rec.color_stop[15:8]});
        mul_b = $signed({1'b0, t});
      end
      S_R_M4: begin
        mul_a = 34'sd255;
        mul_b = $signed({1'b0, t});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = rec;
    ram_raddr = ptr;
    div_start = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      S_E_WR: begin
        ram_we          = 1'b1;
        ram_waddr       = emit_slot;
        ram_wdata.angle = prod[47:16];
      end
      S_T_CHK: begin
        // retire a slot found with no life left
        ram_we           = ram_rdata.active && (ram_rdata.life_left == 32'd0);
        ram_wdata        = ram_rdata;
        ram_wdata.active = 1'b0;
      end
      S_T_MY: begin
        ram_we              = 1'b1;
        ram_wdata.pos_y     = pos_y_new;
        ram_wdata.angle     = rec.angle + {22'd0, rot_full[25:16]};
        ram_wdata.life_left = life_new;
      end
      S_R_RD: begin
        ram_raddr = idx_ext[SW-1:0];
      end
      S_R_CHK: begin
        div_start = ram_rdata.active && (ram_rdata.life_total != 32'd0);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_begin  <= 32'hFFFFFFFF;
      color_end    <= 32'd0;
      vel_spread_x <= 31'd0;
      vel_spread_y <= 31'd0;
      size_begin   <= 32'sd65536;
      size_spread  <= 31'd0;
      size_end     <= 32'sd0;
      lifetime     <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COLOR_BEGIN:  color_begin  <= cfg_data;
        REG_COLOR_END:    color_end    <= cfg_data;
        REG_VEL_SPREAD_X: vel_spread_x <= cfg_data[30:0];
        REG_VEL_SPREAD_Y: vel_spread_y <= cfg_data[30:0];
        REG_SIZE_BEGIN:   size_begin   <= cfg_data;
        REG_SIZE_SPREAD:  size_spread  <= cfg_data[30:0];
        REG_SIZE_END:     size_end     <= cfg_data;
        REG_LIFETIME:     lifetime     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ptr       <= '0;
      emit_slot <= LAST;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + SW'(1);
          if (ptr == LAST) begin
            ptr   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            rq  <= req;
            ptr <= '0;
            rec.active      <= 1'b1;
            rec.pos_x       <= req.spawn_x;
            rec.pos_y       <= req.spawn_y;
            rec.life_left   <= lifetime;
            rec.life_total  <= lifetime;
            rec.color_start <= color_begin;
            rec.color_stop  <= color_end;
            rec.size_stop   <= size_end;
            unique case (req.req_type)
              REQ_EMIT:   state <= S_E_VX;
              REQ_TICK:   state <= S_T_RD;
              REQ_RENDER: state <= S_R_RD;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_E_VX:  state <= S_E_VY;
        S_E_VY: begin
          rec.vel_x <= jit;
          state     <= S_E_SZ;
        end
        S_E_SZ: begin
          rec.vel_y <= jit;
          state     <= S_E_ANG;
        end
        S_E_ANG: begin
          rec.size_start <= jit;
          state          <= S_E_WR;
        end
        S_E_WR: begin
          emit_slot <= (emit_slot == '0) ? LAST : emit_slot - SW'(1);
          state     <= S_IDLE;
        end
        S_T_RD:  state <= S_T_CHK;
        S_T_CHK: begin
          rec <= ram_rdata;
          if (ram_rdata.active && (ram_rdata.life_left != 32'd0)) begin
            state <= S_T_MX;
          end else if (ptr == LAST) begin
            state <= S_IDLE;
          end else begin
            ptr   <= ptr + SW'(1);
            state <= S_T_RD;
          end
        end
        S_T_MX: begin
          rec.pos_x <= sat32(37'(rec.pos_x) + 37'(ps));
          state     <= S_T_MY;
        end
        S_T_MY: begin
          if (ptr == LAST) begin
            state <= S_IDLE;
          end else begin
            ptr   <= ptr + SW'(1);
            state <= S_T_RD;
          end
        end
        S_R_RD: begin
          if (idx_ok) begin
            state <= S_R_CHK;
          end else begin
            rsp       <= '0;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_R_CHK: begin
          rec <= ram_rdata;
          t   <= 17'd0;
          if (!ram_rdata.active) begin
            rsp       <= '0;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (ram_rdata.life_total == 32'd0) begin
            state <= S_R_M0;
          end else begin
            state <= S_R_DIV;
          end
        end
        S_R_DIV: begin
          if (div_done) begin
            t     <= div_q;
            state <= S_R_M0;
          end
        end
        S_R_M0: begin
          rsp.shown      <= 1'b1;
          rsp.quad_x     <= rec.pos_x;
          rsp.quad_y     <= rec.pos_y;
          rsp.quad_angle <= rec.angle;
          state          <= S_R_M1;
        end
        S_R_M1: begin
          rsp.quad_size <= rec.size_stop + ps[31:0];
          state         <= S_R_M2;
        end
        S_R_M2: begin
          rsp.red <= rec.color_stop[31:24] + ps[7:0];
          state   <= S_R_M3;
        end
        S_R_M3: begin
          rsp.green <= rec.color_stop[23:16] + ps[7:0];
          state     <= S_R_M4;
        end
        S_R_M4: begin
          rsp.blue <= rec.color_stop[15:8] + ps[7:0];
          state    <= S_R_OUT;
        end
        S_R_OUT: begin
          rsp.alpha <= ps[7:0];
          rsp_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ppe_ram #(.WIDTH(REC_W), .DEPTH(POOL_SIZE)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ppe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  ppe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (ram_rdata.life_left),
    .den   (ram_rdata.life_total),
    .done  (div_done),
    .quot  (div_q)
  );

`ifndef NO_ASSERTIONS
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("clearing pass not started after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req.req_type != REQ_NONE) |=> busy)
    else $error("transaction accepted without going busy");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !busy)
    else $error("result issued while sequencer still busy");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.shown |-> (rsp.alpha == 8'd0) && (rsp.quad_x == 32'sd0))
    else $error("inactive slot result not cleared");
`endif

endmodule
